@@ hw/rtl/edp_pkg.sv @@
// Shared types and constants for the encoder drive PID block.
// Payload structs, controller/datapath command and status, register indexes.
// No dependencies.
`default_nettype none

package edp_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_INCHES = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN    = 8'd3;

    localparam logic [30:0] INTEG_GAIN_RST = 31'd168;
    localparam logic [30:0] DERIV_GAIN_RST = 31'd50331648;

    // 900 / (4.125 * pi) in Q16.16
    localparam logic signed [31:0] TICKS_PER_INCH_Q16 = 32'sd4551438;
    localparam logic signed [31:0] SETTLE_BAND        = 32'sd10;
    localparam logic [31:0]        SETTLE_MS          = 32'd250;
    localparam logic signed [7:0]  DRIVE_MAX          = 8'sd127;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] position;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              settled;
    } out_item_t;

    typedef enum logic [1:0] {
        MUL_TGT,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_SETTLED,
        OUT_DRIVE
    } out_kind_t;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      acc_clr;
        logic      acc_add;
        logic      tick;
        logic      tare;
        logic      update;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic done;
        logic settle_hit;
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/edp_datapath.sv @@
// Datapath of the encoder drive PID: config registers, control state,
// one shared 33x32 multiplier, accumulator and output register. Uses edp_pkg.
`default_nettype none

module edp_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire edp_pkg::cmd_t                  cmd,
    output edp_pkg::status_t                    status,
    input  wire edp_pkg::in_item_t              s_data,
    output edp_pkg::out_item_t                  m_data,
    input  wire logic                           cfg_valid,
    input  wire logic [edp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [edp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import edp_pkg::*;

    logic signed [11:0] target_inches_reg;
    logic [30:0]        prop_gain_reg;
    logic [30:0]        integ_gain_reg;
    logic [30:0]        deriv_gain_reg;

    logic signed [31:0] zero_offset_reg;
    logic signed [31:0] integral_sum_reg;
    logic signed [31:0] last_error_reg;
    logic [31:0]        active_stamp_reg;
    logic               done_reg;

    in_item_t           item_reg;
    logic signed [64:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic signed [18:0] ticks_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] deriv_reg;
    out_item_t          out_reg;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] prod_next;

    logic signed [64:0] tq_full;
    logic               tq_rnd;
    logic signed [18:0] ticks_next;

    logic signed [31:0] rel;
    logic signed [32:0] diff;
    logic signed [31:0] err_next;
    logic signed [32:0] deriv_next;
    logic signed [32:0] isum;
    logic signed [31:0] integral_next;
    logic               in_band;
    logic [31:0]        stamp_next;
    logic [31:0]        elapsed;

    logic signed [65:0] dq_full;
    logic               dq_rnd;
    logic signed [65:0] dq;
    logic signed [7:0]  drive_next;

    always_comb begin
        case (cmd.mul_sel)
            MUL_TGT: begin
                mul_a = 33'(target_inches_reg);
                mul_b = TICKS_PER_INCH_Q16;
            end
            MUL_P: begin
                mul_a = 33'(err_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            MUL_I: begin
                mul_a = 33'(integral_sum_reg);
                mul_b = $signed({1'b0, integ_gain_reg});
            end
            MUL_D: begin
                mul_a = deriv_reg;
                mul_b = $signed({1'b0, deriv_gain_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 65'(mul_a) * 65'(mul_b);
    end

    // target ticks, truncated toward zero
    always_comb begin
        tq_full    = prod_reg >>> 16;
        tq_rnd     = prod_reg[64] && (prod_reg[15:0] != 16'd0);
        ticks_next = tq_full[18:0] + 19'(tq_rnd);
    end

    always_comb begin
        rel  = item_reg.position - zero_offset_reg;
        diff = 33'(ticks_reg) - 33'(rel);
        if (diff[32] != diff[31]) begin
            err_next = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            err_next = diff[31:0];
        end
        deriv_next = 33'(err_next) - 33'(last_error_reg);
        in_band    = (err_next < SETTLE_BAND) && (err_next > -SETTLE_BAND);
        isum       = 33'(integral_sum_reg) + 33'(err_next);
        if (isum[32] != isum[31]) begin
            integral_next = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            integral_next = isum[31:0];
        end
        stamp_next = (last_error_reg > SETTLE_BAND) ? item_reg.now_ms : active_stamp_reg;
        elapsed    = item_reg.now_ms - stamp_next;
    end

    always_comb begin
        dq_full = acc_reg >>> 24;
        dq_rnd  = acc_reg[65] && (acc_reg[23:0] != 24'd0);
        dq      = dq_full + 66'(dq_rnd);
        if (dq > 66'(DRIVE_MAX)) begin
            drive_next = DRIVE_MAX;
        end else if (dq < -66'(DRIVE_MAX)) begin
            drive_next = -DRIVE_MAX;
        end else begin
            drive_next = dq[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_inches_reg <= '0;
            prop_gain_reg     <= '0;
            integ_gain_reg    <= INTEG_GAIN_RST;
            deriv_gain_reg    <= DERIV_GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TARGET_INCHES: target_inches_reg <= cfg_data[11:0];
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[30:0];
                REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[30:0];
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg  <= '0;
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
            active_stamp_reg <= '0;
            done_reg         <= 1'b0;
        end else if (cmd.tare) begin
            zero_offset_reg  <= item_reg.position;
            integral_sum_reg <= '0;
            last_error_reg   <= 32'(ticks_reg);
            active_stamp_reg <= '0;
            done_reg         <= 1'b0;
        end else if (cmd.update) begin
            if (in_band) begin
                integral_sum_reg <= integral_next;
            end
            last_error_reg   <= err_next;
            active_stamp_reg <= stamp_next;
            if (elapsed >= SETTLE_MS) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.tick) begin
            ticks_reg <= ticks_next;
        end
        if (cmd.update) begin
            err_reg   <= err_next;
            deriv_reg <= deriv_next;
        end
        if (cmd.acc_clr) begin
            acc_reg <= 66'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + 66'(prod_reg);
        end
        if (cmd.out_load) begin
            case (cmd.out_kind)
                OUT_ZERO: begin
                    out_reg.drive   <= '0;
                    out_reg.settled <= 1'b0;
                end
                OUT_SETTLED: begin
                    out_reg.drive   <= '0;
                    out_reg.settled <= 1'b1;
                end
                OUT_DRIVE: begin
                    out_reg.drive   <= drive_next;
                    out_reg.settled <= 1'b0;
                end
                default: begin
                    out_reg.drive   <= '0;
                    out_reg.settled <= 1'b0;
                end
            endcase
        end
    end

    assign status.mode       = item_reg.mode;
    assign status.done       = done_reg;
    assign status.settle_hit = (elapsed >= SETTLE_MS);
    assign m_data            = out_reg;

`ifndef SYNTHESIS
    a_tare_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tare |=> (integral_sum_reg == 32'sd0 && !done_reg && active_stamp_reg == 32'd0))
        else $error("tare left control state behind");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.out_load) |-> (out_reg.drive != -8'sd128))
        else $error("drive outside +-127");

    a_settled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.out_load) && out_reg.settled) |-> (out_reg.drive == 8'sd0))
        else $error("settled item with nonzero drive");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/edp_ctrl.sv @@
// Controller of the encoder drive PID: sequences the shared multiplier,
// state update and output register; owns both handshakes. Uses edp_pkg.
`default_nettype none

module edp_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire edp_pkg::status_t status,
    output edp_pkg::cmd_t         cmd
);
    import edp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT,
        ST_TICK,
        ST_START,
        ST_ERR,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t    state_reg, state_next;
    out_kind_t kind_reg, kind_next;
    logic      m_valid_reg, m_valid_next;
    logic      out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_sel  = MUL_TGT;
        cmd.out_kind = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TGT;
                end
            end
            ST_TGT: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TGT;
                if (status.mode && status.done) begin
                    kind_next  = OUT_SETTLED;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                cmd.tick   = 1'b1;
                state_next = status.mode ? ST_ERR : ST_START;
            end
            ST_START: begin
                cmd.tare   = 1'b1;
                kind_next  = OUT_ZERO;
                state_next = ST_OUT;
            end
            ST_ERR: begin
                cmd.update = 1'b1;
                if (status.settle_hit) begin
                    kind_next  = OUT_SETTLED;
                    state_next = ST_OUT;
                end else begin
                    kind_next  = OUT_DRIVE;
                    state_next = ST_MP;
                end
            end
            ST_MP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = ST_MI;
            end
            ST_MI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                cmd.acc_clr = 1'b1;
                state_next  = ST_MD;
            end
            ST_MD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= OUT_ZERO;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten before taken");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/encoder_drive_pid.sv @@
// Encoder drive PID, top level: joins controller and datapath.
// Depends on edp_pkg, edp_ctrl, edp_datapath.
//
// Input channel s_*: one item per move start (mode 0, tares the encoder) or
// per control sample (mode 1). Result channel m_*: one item per input item,
// drive (-127..127) and settled. Config channel cfg_*: index and data, always
// ready; write only while no item is in progress.
// A control sample steps through target, tick, error update, P, I, D, sum and
// output, or from the error update to output once the settle time is reached.
// A start item steps through target, tick, tare; a sample after the move has
// settled, target and output. One item at a time: the single 33x32 multiplier
// forms target, P, I and D products in turn. The next item is accepted as
// soon as the previous result sits in the output register, even if it is not
// yet taken. If the receiver stalls, the result waits; a following item is
// worked on and then holds until the register frees.
// Reset (aresetn low, synchronous) clears the control state, the tare
// offset, integral, error history, timestamp and settled flag, and loads the
// default gains.
`default_nettype none

module encoder_drive_pid (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire edp_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output edp_pkg::out_item_t                   m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [edp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [edp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import edp_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    edp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    edp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
